@@ rtl/core/sobel_edge_magnitude_rgb_top_assert.svh @@
// Assertion macros shared by the Sobel edge magnitude RTL.
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_TOP_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SEM_ASSERT(lbl, prop) lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
  (prop)) else $error("sem assertion failed");
`define SEM_ASSERT_NEXT(lbl, pre, post) lbl: assert property (@(posedge clk_i) \
  disable iff (!rst_ni) (pre) |=> (post)) else $error("sem assertion failed");
`else
`define SEM_ASSERT(lbl, prop)
`define SEM_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

@@ rtl/core/sem_pkg.sv @@
// Package with sizes, codes and controller interface types of the Sobel block.
package sem_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int W_W = 11;
  localparam int H_W = 16;
  localparam int ROW_W = H_W + 1;
  localparam int EMIT_W = 26;
  localparam int N_W = W_W + H_W;
  localparam int P_W = ROW_W + W_W;
  localparam int PIX_W = 24;
  localparam int CNT_W = $clog2(EMIT_W + 1);

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic ADDR_WIDTH_REG = 1'b0;
  localparam logic ADDR_HEIGHT_REG = 1'b1;

  typedef struct packed {
    logic capture;
    logic check;
    logic calc_p;
    logic rd;
    logic wr;
    logic p_inc;
    logic div_start;
    logic div_step;
    logic grad;
    logic square;
    logic rt_step;
    logic rt_round;
    logic load;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_drain;
    logic p_ge_n;
    logic p_ge_w1;
    logic div_done;
    logic rt_done;
    logic last_ch;
    logic out_busy;
  } ctl_status_t;

endpackage

@@ rtl/core/sobel_edge_magnitude_rgb_top.sv @@
// Top level of the streaming RGB Sobel gradient magnitude block.
//
//   channel  | direction | signals
//   ---------+-----------+-------------------------------------------------------
//   input    | in        | in_valid_i/in_ready_o, command_i, red/green/blue_in_i
//   output   | out       | out_valid_o/out_ready_i, red/green/blue_edge_o, last_of_frame_o
//   config   | in/out    | psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// An item that emits a result runs a line-store read and write (repeated for the
// first drain of a one-row frame), the 26-step position divider once, and the
// 8-step square root once for each of the three colors.
// Reset clears counters, window and control; the line stores need no clearing.
// A result waits in the output register while the next item is taken; a further
// result holds the input stalled until the output register is free.
module sobel_edge_magnitude_rgb_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  red_edge_o,
  output logic [7:0]  green_edge_o,
  output logic [7:0]  blue_edge_o,
  output logic        last_of_frame_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [sem_pkg::W_W-1:0] width_q;
  logic [sem_pkg::H_W-1:0] height_q;
  logic                    wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= sem_pkg::W_W'(sem_pkg::MAX_WIDTH);
      height_q <= sem_pkg::H_W'(1);
    end else if (wr_en) begin
      unique case (paddr[2])
        sem_pkg::ADDR_WIDTH_REG: width_q <= pwdata[sem_pkg::W_W-1:0];
        sem_pkg::ADDR_HEIGHT_REG: height_q <= pwdata[sem_pkg::H_W-1:0];
        default: width_q <= width_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      sem_pkg::ADDR_WIDTH_REG: prdata = {{(32-sem_pkg::W_W){1'b0}}, width_q};
      sem_pkg::ADDR_HEIGHT_REG: prdata = {{(32-sem_pkg::H_W){1'b0}}, height_q};
      default: prdata = '0;
    endcase
  end

  sem_pkg::ctl_cmd_t    cmd;
  sem_pkg::ctl_status_t status;

  sem_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  sem_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_width_i    (width_q),
    .cfg_height_i   (height_q),
    .command_i      (command_i),
    .red_in_i       (red_in_i),
    .green_in_i     (green_in_i),
    .blue_in_i      (blue_in_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .red_edge_o     (red_edge_o),
    .green_edge_o   (green_edge_o),
    .blue_edge_o    (blue_edge_o),
    .last_of_frame_o(last_of_frame_o)
  );

endmodule

@@ rtl/core/sem_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sem_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/sem_datapath.sv @@
// Datapath: line stores, window, counters, divider, gradients and square root.
`include "sobel_edge_magnitude_rgb_top_assert.svh"
module sem_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sem_pkg::ctl_cmd_t     cmd_i,
  output sem_pkg::ctl_status_t  status_o,
  input  logic [sem_pkg::W_W-1:0] cfg_width_i,
  input  logic [sem_pkg::H_W-1:0] cfg_height_i,
  input  logic                  command_i,
  input  logic [7:0]            red_in_i,
  input  logic [7:0]            green_in_i,
  input  logic [7:0]            blue_in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            red_edge_o,
  output logic [7:0]            green_edge_o,
  output logic [7:0]            blue_edge_o,
  output logic                  last_of_frame_o
);

  localparam int COL_W = sem_pkg::COL_W;
  localparam int W_W = sem_pkg::W_W;
  localparam int H_W = sem_pkg::H_W;
  localparam int ROW_W = sem_pkg::ROW_W;
  localparam int EMIT_W = sem_pkg::EMIT_W;
  localparam int N_W = sem_pkg::N_W;
  localparam int P_W = sem_pkg::P_W;
  localparam int PIX_W = sem_pkg::PIX_W;
  localparam int CNT_W = sem_pkg::CNT_W;

  logic [W_W-1:0] w_eff;
  logic [H_W-1:0] h_eff;

  always_comb begin
    if (cfg_width_i == '0) begin
      w_eff = W_W'(1);
    end else if (cfg_width_i > W_W'(sem_pkg::MAX_WIDTH)) begin
      w_eff = W_W'(sem_pkg::MAX_WIDTH);
    end else begin
      w_eff = cfg_width_i;
    end
    h_eff = (cfg_height_i == '0) ? H_W'(1) : cfg_height_i;
  end

  logic [N_W-1:0]    n_q;
  logic              cmd_q;
  logic [PIX_W-1:0]  pix_q;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [EMIT_W-1:0] emit_q, emit_d;
  logic [PIX_W-1:0]  win_q [9];
  logic [PIX_W-1:0]  win_d [9];
  logic [P_W-1:0]    p_q;
  logic [EMIT_W-1:0] quo_q;
  logic [W_W-1:0]    rem_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [1:0]        ch_q;
  logic signed [11:0] gx_q, gy_q;
  logic [20:0]       s_q;
  logic              sat_q;
  logic [7:0]        q_q, bit_q;
  logic [7:0]        res_q [3];
  logic              out_valid_q, last_q;

  logic [PIX_W-1:0] up_rd, mid_rd, pix_wr;
  logic             restart;

  assign pix_wr = (cmd_q == sem_pkg::CMD_DRAIN) ? '0 : pix_q;

  sem_ram #(.WIDTH(PIX_W), .DEPTH(sem_pkg::MAX_WIDTH)) u_upper (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr),
    .waddr_i(col_q),
    .wdata_i(mid_rd),
    .raddr_i(col_q),
    .rdata_o(up_rd)
  );

  sem_ram #(.WIDTH(PIX_W), .DEPTH(sem_pkg::MAX_WIDTH)) u_middle (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr),
    .waddr_i(col_q),
    .wdata_i(pix_wr),
    .raddr_i(col_q),
    .rdata_o(mid_rd)
  );

  logic last_hit;
  assign last_hit = (N_W'(emit_q) + N_W'(1)) == n_q;
  assign restart = (cmd_i.check && (({1'b0, col_q} >= w_eff) || (N_W'(emit_q) >= n_q)))
                   || (cmd_i.load && last_hit);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    emit_d = emit_q;
    for (int k = 0; k < 9; k++) begin
      win_d[k] = win_q[k];
    end
    if (restart) begin
      col_d = '0;
      row_d = '0;
      emit_d = '0;
      for (int k = 0; k < 9; k++) begin
        win_d[k] = '0;
      end
    end else if (cmd_i.wr) begin
      for (int k = 0; k < 3; k++) begin
        win_d[k*3] = win_q[k*3+1];
        win_d[k*3+1] = win_q[k*3+2];
      end
      win_d[2] = up_rd;
      win_d[5] = mid_rd;
      win_d[8] = pix_wr;
      if ((W_W'(col_q) + W_W'(1)) >= w_eff) begin
        col_d = '0;
        row_d = row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end else if (cmd_i.load) begin
      emit_d = emit_q + EMIT_W'(1);
    end
  end

  // Divider step: emitted count over the width gives the result's row and column.
  logic [W_W:0] rem_t;
  logic         rem_ge;
  assign rem_t = {rem_q, quo_q[EMIT_W-1]};
  assign rem_ge = rem_t >= {1'b0, w_eff};

  // Border masks and masked window bytes for the current channel.
  logic rowok [3];
  logic colok [3];
  assign rowok[0] = quo_q != '0;
  assign rowok[1] = 1'b1;
  assign rowok[2] = ({1'b0, quo_q} + (EMIT_W+1)'(1)) < (EMIT_W+1)'(h_eff);
  assign colok[0] = rem_q != '0;
  assign colok[1] = 1'b1;
  assign colok[2] = (rem_q + W_W'(1)) < w_eff;

  logic signed [11:0] v [9];
  logic signed [11:0] gx_d, gy_d;
  logic [7:0]         byte_sel [9];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        unique case (ch_q)
          2'd0:    byte_sel[i*3+j] = win_q[i*3+j][23:16];
          2'd1:    byte_sel[i*3+j] = win_q[i*3+j][15:8];
          default: byte_sel[i*3+j] = win_q[i*3+j][7:0];
        endcase
        v[i*3+j] = (rowok[i] && colok[j]) ? $signed({4'b0, byte_sel[i*3+j]}) : 12'sd0;
      end
    end
    gx_d = (v[2] - v[0]) + ((v[5] - v[3]) <<< 1) + (v[8] - v[6]);
    gy_d = (v[6] + (v[7] <<< 1) + v[8]) - (v[0] + (v[1] <<< 1) + v[2]);
  end

  logic signed [23:0] gx2, gy2;
  logic [20:0]        s_d;
  assign gx2 = gx_q * gx_q;
  assign gy2 = gy_q * gy_q;
  assign s_d = gx2[20:0] + gy2[20:0];

  logic [7:0]  t;
  logic [15:0] tt, qq, diff;
  logic [8:0]  qr;
  logic [7:0]  res_d;
  assign t = q_q | bit_q;
  assign tt = t * t;
  assign qq = q_q * q_q;
  assign diff = s_q[15:0] - qq;
  assign qr = (diff > {8'b0, q_q}) ? ({1'b0, q_q} + 9'd1) : {1'b0, q_q};
  assign res_d = (sat_q || qr[8]) ? 8'hFF : qr[7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      emit_q <= '0;
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= '0;
      end
      cnt_q <= '0;
      ch_q <= '0;
      bit_q <= '0;
      out_valid_q <= 1'b0;
      n_q <= '0;
    end else begin
      n_q <= N_W'(w_eff) * N_W'(h_eff);
      col_q <= col_d;
      row_q <= row_d;
      emit_q <= emit_d;
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= win_d[k];
      end
      if (cmd_i.div_start) begin
        cnt_q <= CNT_W'(EMIT_W);
        ch_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end else if (cmd_i.rt_round && ch_q != 2'd2) begin
        ch_q <= ch_q + 2'd1;
      end
      if (cmd_i.square) begin
        bit_q <= 8'h80;
      end else if (cmd_i.rt_step) begin
        bit_q <= bit_q >> 1;
      end
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q <= command_i;
      pix_q <= {red_in_i, green_in_i, blue_in_i};
    end
    if (cmd_i.calc_p) begin
      p_q <= P_W'(row_q) * P_W'(w_eff) + P_W'(col_q);
    end else if (cmd_i.p_inc) begin
      p_q <= p_q + P_W'(1);
    end
    if (cmd_i.div_start) begin
      quo_q <= emit_q;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_ge ? W_W'(rem_t - {1'b0, w_eff}) : rem_t[W_W-1:0];
      quo_q <= {quo_q[EMIT_W-2:0], rem_ge};
    end
    if (cmd_i.grad) begin
      gx_q <= gx_d;
      gy_q <= gy_d;
    end
    if (cmd_i.square) begin
      s_q <= s_d;
      sat_q <= s_d > 21'd65280;
      q_q <= '0;
    end else if (cmd_i.rt_step) begin
      if (tt <= s_q[15:0]) begin
        q_q <= t;
      end
    end
    if (cmd_i.rt_round) begin
      res_q[ch_q] <= res_d;
    end
    if (cmd_i.load) begin
      red_edge_o <= res_q[0];
      green_edge_o <= res_q[1];
      blue_edge_o <= res_q[2];
      last_q <= last_hit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign last_of_frame_o = last_q;

  assign status_o.is_drain = cmd_q == sem_pkg::CMD_DRAIN;
  assign status_o.p_ge_n = p_q >= P_W'(n_q);
  assign status_o.p_ge_w1 = p_q >= (P_W'(w_eff) + P_W'(1));
  assign status_o.div_done = cnt_q == CNT_W'(1);
  assign status_o.rt_done = bit_q[0];
  assign status_o.last_ch = ch_q == 2'd2;
  assign status_o.out_busy = out_valid_q && !out_ready_i;

  `SEM_ASSERT(a_load_free, cmd_i.load |-> (!out_valid_q || out_ready_i))
  `SEM_ASSERT_NEXT(a_col_after_shift, cmd_i.wr, W_W'(col_q) < w_eff)
  `SEM_ASSERT_NEXT(a_col_after_check, cmd_i.check, W_W'(col_q) < w_eff)

endmodule

@@ rtl/core/sem_ctrl.sv @@
// Controller state machine sequencing one item through the datapath.
`include "sobel_edge_magnitude_rgb_top_assert.svh"
module sem_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sem_pkg::ctl_status_t status_i,
  output sem_pkg::ctl_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_CALCP, ST_DECIDE, ST_RD, ST_WR, ST_POST,
    ST_DIV, ST_GRAD, ST_SQR, ST_ROOT, ST_ROUND, ST_LOAD
  } state_e;

  state_e state_q, state_d;
  logic   k_q, k_d;

  always_comb begin
    state_d = state_q;
    k_d = k_q;
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d = ST_CALCP;
      end
      ST_CALCP: begin
        cmd_o.calc_p = 1'b1;
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        k_d = 1'b0;
        state_d = (status_i.is_drain == status_i.p_ge_n) ? ST_RD : ST_IDLE;
      end
      ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d = ST_WR;
      end
      ST_WR: begin
        cmd_o.wr = 1'b1;
        state_d = ST_POST;
      end
      ST_POST: begin
        priority if (status_i.p_ge_w1) begin
          cmd_o.div_start = 1'b1;
          state_d = ST_DIV;
        end else if (status_i.is_drain && !k_q) begin
          cmd_o.p_inc = 1'b1;
          k_d = 1'b1;
          state_d = ST_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) begin
          state_d = ST_GRAD;
        end
      end
      ST_GRAD: begin
        cmd_o.grad = 1'b1;
        state_d = ST_SQR;
      end
      ST_SQR: begin
        cmd_o.square = 1'b1;
        state_d = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.rt_step = 1'b1;
        if (status_i.rt_done) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd_o.rt_round = 1'b1;
        state_d = status_i.last_ch ? ST_LOAD : ST_GRAD;
      end
      ST_LOAD: begin
        if (!status_i.out_busy) begin
          cmd_o.load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q <= k_d;
    end
  end

  assign in_ready_o = state_q == ST_IDLE;

  `SEM_ASSERT_NEXT(a_one_item, in_valid_i && in_ready_o, !in_ready_o)

endmodule
